// ===== hdl/lfps_pkg.sv =====
// Shared widths, register codes and reset values for the line-follow steering block.
`default_nettype none
package lfps_pkg;
   localparam int COLUMN_W = 9;
   localparam int ERR_W = COLUMN_W + 1;
   localparam int DERIV_W = ERR_W + 1;
   localparam int GAIN_W = 24;
   localparam int BASE_W = 7;
   localparam int POWER_W = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = GAIN_W;
   localparam int TERM_LIMIT_EXP = 60;
   localparam int TERM_W = TERM_LIMIT_EXP + 2;
   localparam int CTRL_W = TERM_W + 1;
   localparam int POWER_LIMIT = 100;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CENTER_COLUMN = 3'd0,
      CSR_GAIN_P        = 3'd1,
      CSR_GAIN_I        = 3'd2,
      CSR_GAIN_D        = 3'd3,
      CSR_BASE_POWER    = 3'd4
   } csr_index_type;

   localparam logic [COLUMN_W-1:0] CENTER_RESET = 9'd250;
   localparam logic [GAIN_W-1:0] GAIN_P_RESET = 24'd11796;
   localparam logic [GAIN_W-1:0] GAIN_I_RESET = 24'd655;
   localparam logic [GAIN_W-1:0] GAIN_D_RESET = 24'd655;
   localparam logic [BASE_W-1:0] BASE_RESET = 7'd80;
endpackage
`default_nettype wire

// ===== hdl/lfps_req_if.sv =====
// Input channel carrying one line centroid column per word.
`default_nettype none
interface lfps_req_if;
   import lfps_pkg::*;
   logic                valid;
   logic                ready;
   logic [COLUMN_W-1:0] line_column;
   modport source (output valid, output line_column, input ready);
   modport sink (input valid, input line_column, output ready);
endinterface
`default_nettype wire

// ===== hdl/lfps_rsp_if.sv =====
// Result channel carrying the left and right motor powers per word.
`default_nettype none
interface lfps_rsp_if;
   import lfps_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [POWER_W-1:0] left_power;
   logic signed [POWER_W-1:0] right_power;
   modport source (output valid, output left_power, output right_power, input ready);
   modport sink (input valid, input left_power, input right_power, output ready);
endinterface
`default_nettype wire

// ===== hdl/lfps_error.sv =====
// Error, derivative and saturating integral stage holding the controller state.
`default_nettype none
module lfps_error #(
   parameter int SUM_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                advance,
   input  wire logic                                in_valid,
   input  wire logic [lfps_pkg::COLUMN_W-1:0]       column,
   input  wire logic [lfps_pkg::COLUMN_W-1:0]       center,
   output logic signed [lfps_pkg::ERR_W-1:0]        err_ff,
   output logic signed [lfps_pkg::DERIV_W-1:0]      deriv_ff,
   output logic signed [SUM_BITS-1:0]               error_sum_ff
);
   import lfps_pkg::*;

   localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

   logic signed [ERR_W-1:0]    err_in;
   logic signed [DERIV_W-1:0]  deriv_in;
   logic signed [SUM_BITS:0]   wide_sum;
   logic signed [SUM_BITS-1:0] error_sum_in;
   logic signed [ERR_W-1:0]    last_error_ff;

   always_comb begin
      err_in = $signed({1'b0, center}) - $signed({1'b0, column});
      deriv_in = DERIV_W'(err_in) - DERIV_W'(last_error_ff);
      wide_sum = (SUM_BITS+1)'(error_sum_ff) + (SUM_BITS+1)'(err_in);
      // clip the integral when the extra top bit disagrees with the sign
      if (wide_sum[SUM_BITS] != wide_sum[SUM_BITS-1]) begin
         error_sum_in = wide_sum[SUM_BITS] ? SUM_MIN : SUM_MAX;
      end else begin
         error_sum_in = wide_sum[SUM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff  <= '0;
         last_error_ff <= '0;
      end else if (advance && in_valid) begin
         error_sum_ff  <= error_sum_in;
         last_error_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         err_ff   <= err_in;
         deriv_ff <= deriv_in;
      end
   end
endmodule
`default_nettype wire

// ===== hdl/lfps_term.sv =====
// One gain product with magnitude saturation at two to the sixtieth.
`default_nettype none
module lfps_term #(
   parameter int VALUE_W = 10
) (
   input  wire logic signed [VALUE_W-1:0]          value,
   input  wire logic [lfps_pkg::GAIN_W-1:0]        gain,
   output logic signed [lfps_pkg::TERM_W-1:0]      term
);
   import lfps_pkg::*;

   localparam int PROD_W = VALUE_W + GAIN_W;
   localparam int CMP_W = (PROD_W > TERM_W) ? PROD_W : TERM_W;

   logic [VALUE_W-1:0] mag;
   logic [PROD_W-1:0]  prod;
   logic [CMP_W-1:0]   prod_x;
   logic [CMP_W-1:0]   limit_x;
   logic [TERM_W-1:0]  sat_mag;

   always_comb begin
      mag = value[VALUE_W-1] ? $unsigned(-value) : $unsigned(value);
      prod = PROD_W'(mag) * PROD_W'(gain);
      prod_x = CMP_W'(prod);
      limit_x = CMP_W'(1) << TERM_LIMIT_EXP;
      sat_mag = (prod_x > limit_x) ? TERM_W'(limit_x) : TERM_W'(prod_x);
      term = value[VALUE_W-1] ? -$signed(sat_mag) : $signed(sat_mag);
   end
endmodule
`default_nettype wire

// ===== hdl/lfps_mix.sv =====
// Takes twice the correction off one motor, then clamps and truncates to percent.
`default_nettype none
module lfps_mix #(
   parameter int GAIN_FRAC_BITS = 16
) (
   input  wire logic signed [lfps_pkg::CTRL_W-1:0]  control,
   input  wire logic [lfps_pkg::BASE_W-1:0]         base_power,
   output logic signed [lfps_pkg::POWER_W-1:0]      left_power,
   output logic signed [lfps_pkg::POWER_W-1:0]      right_power
);
   import lfps_pkg::*;

   localparam int PW = CTRL_W + 2;

   logic signed [PW-1:0] base_fx;
   logic signed [PW-1:0] twice;
   logic signed [PW-1:0] left_fx;
   logic signed [PW-1:0] right_fx;

   function automatic logic signed [POWER_W-1:0] to_percent(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] lim;
      logic signed [PW-1:0] clip;
      logic signed [PW-1:0] whole;
      lim = PW'(POWER_LIMIT) <<< GAIN_FRAC_BITS;
      clip = p;
      if (clip > lim) clip = lim;
      if (clip < -lim) clip = -lim;
      // round toward zero: bias negatives up before the arithmetic shift
      if (clip < 0) begin
         whole = (clip + ((PW'(1) <<< GAIN_FRAC_BITS) - PW'(1))) >>> GAIN_FRAC_BITS;
      end else begin
         whole = clip >>> GAIN_FRAC_BITS;
      end
      return whole[POWER_W-1:0];
   endfunction

   always_comb begin
      base_fx = $signed(PW'(base_power)) <<< GAIN_FRAC_BITS;
      twice = $signed({control[CTRL_W-1], control, 1'b0});
      left_fx = base_fx;
      right_fx = base_fx;
      if (control > 0) begin
         left_fx = base_fx - twice;
      end else if (control < 0) begin
         right_fx = base_fx + twice;
      end
      left_power = to_percent(left_fx);
      right_power = to_percent(right_fx);
   end
endmodule
`default_nettype wire

// ===== hdl/line_follow_pid_steering.sv =====
// Line-follow PID steering: centroid column in, left and right motor powers out.
// One result word per input word. The block accepts a word every cycle while no
// finished word is stalled at the output. A word passes five registers (input
// register, error/integral stage, gain products, correction sum, power output
// register) on its way to the result channel. The rate is set by the integral
// update, a saturating add whose result feeds the next word. A stall on the
// result side holds the whole pipeline; the input is ready whenever the output
// register is empty or being taken. Configuration is taken on any cycle with
// csr_we high; indexes beyond the base power are dropped.
`default_nettype none
module line_follow_pid_steering #(
   parameter int GAIN_FRAC_BITS = 16,
   parameter int SUM_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   lfps_req_if.sink                           req_bus,
   lfps_rsp_if.source                         rsp_bus,
   input  wire logic                          csr_we,
   input  wire lfps_pkg::csr_index_type       csr_index,
   input  wire logic [lfps_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lfps_pkg::*;

   logic [COLUMN_W-1:0] center_ff;
   logic [GAIN_W-1:0]   gain_p_ff;
   logic [GAIN_W-1:0]   gain_i_ff;
   logic [GAIN_W-1:0]   gain_d_ff;
   logic [BASE_W-1:0]   base_ff;

   logic advance;
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;

   logic [COLUMN_W-1:0]        col_ff;
   logic signed [ERR_W-1:0]    err_ff;
   logic signed [DERIV_W-1:0]  deriv_ff;
   logic signed [SUM_BITS-1:0] error_sum_ff;
   logic signed [TERM_W-1:0]   term_p_in, term_i_in, term_d_in;
   logic signed [TERM_W-1:0]   term_p_ff, term_i_ff, term_d_ff;
   logic signed [CTRL_W-1:0]   control_in, control_ff;
   logic signed [POWER_W-1:0]  left_in, right_in, left_ff, right_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= CENTER_RESET;
         gain_p_ff <= GAIN_P_RESET;
         gain_i_ff <= GAIN_I_RESET;
         gain_d_ff <= GAIN_D_RESET;
         base_ff   <= BASE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTER_COLUMN: center_ff <= csr_wdata[COLUMN_W-1:0];
            CSR_GAIN_P:        gain_p_ff <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:        gain_i_ff <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D:        gain_d_ff <= csr_wdata[GAIN_W-1:0];
            CSR_BASE_POWER:    base_ff <= csr_wdata[BASE_W-1:0];
            default: ;
         endcase
      end
   end

   // advance every stage together unless a finished word is stuck at the output
   assign advance = !v4_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req_bus.valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   lfps_error #(
      .SUM_BITS(SUM_BITS)
   ) u_error (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (v0_ff),
      .column       (col_ff),
      .center       (center_ff),
      .err_ff       (err_ff),
      .deriv_ff     (deriv_ff),
      .error_sum_ff (error_sum_ff)
   );

   lfps_term #(.VALUE_W(ERR_W)) u_term_p (
      .value (err_ff), .gain (gain_p_ff), .term (term_p_in)
   );
   lfps_term #(.VALUE_W(SUM_BITS)) u_term_i (
      .value (error_sum_ff), .gain (gain_i_ff), .term (term_i_in)
   );
   lfps_term #(.VALUE_W(DERIV_W)) u_term_d (
      .value (deriv_ff), .gain (gain_d_ff), .term (term_d_in)
   );

   assign control_in = CTRL_W'(term_p_ff) + CTRL_W'(term_i_ff) + CTRL_W'(term_d_ff);

   lfps_mix #(
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
   ) u_mix (
      .control     (control_ff),
      .base_power  (base_ff),
      .left_power  (left_in),
      .right_power (right_in)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         col_ff     <= req_bus.line_column;
         term_p_ff  <= term_p_in;
         term_i_ff  <= term_i_in;
         term_d_ff  <= term_d_in;
         control_ff <= control_in;
         left_ff    <= left_in;
         right_ff   <= right_in;
      end
   end

   assign rsp_bus.valid = v4_ff;
   assign rsp_bus.left_power = left_ff;
   assign rsp_bus.right_power = right_ff;

   a_power_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.left_power >= -8'sd100) && (rsp_bus.left_power <= 8'sd100)
                     && (rsp_bus.right_power >= -8'sd100) && (rsp_bus.right_power <= 8'sd100))
      else $error("motor power outside the clamp");

   a_zero_balanced: assert property (@(posedge clock) disable iff (reset)
      v3_ff && advance && (control_ff == '0) |=> (rsp_bus.left_power == rsp_bus.right_power))
      else $error("zero correction gave unequal powers");

   a_positive_steer: assert property (@(posedge clock) disable iff (reset)
      v3_ff && advance && (control_ff > 0) |=> (rsp_bus.left_power <= rsp_bus.right_power))
      else $error("positive correction raised the left side");
endmodule
`default_nettype wire
